>>> rtl/h264_annexb_frame_splitter_core_defines.svh
// Assertion macros for the H.264 Annex B frame splitter.
// Used by the port checker; needs nothing else.
`ifndef H264_ANNEXB_FRAME_SPLITTER_CORE_DEFINES_SVH
`define H264_ANNEXB_FRAME_SPLITTER_CORE_DEFINES_SVH

// Plain property, reset-qualified.
`define H264FS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: property violated");

// Same-cycle implication, reset-qualified.
`define H264FS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication violated");

`endif

>>> rtl/h264fs_pkg.sv
// Shared constants, types and helpers of the H.264 Annex B frame splitter.
// Depends on nothing; every other file but the assertion macros header imports it.
`timescale 1ns / 1ps
`default_nettype none

package h264fs_pkg;

  parameter int unsigned LENGTH_BITS = 20;

  localparam int unsigned LaDepth = 5;
  localparam int unsigned LaFillW = $clog2(LaDepth + 1);

  localparam logic [7:0] ScZero = 8'h00;
  localparam logic [7:0] ScOne  = 8'h01;

  // Unit type codes (low nibble of the header byte).
  localparam logic [3:0] NalSlice = 4'd1;
  localparam logic [3:0] NalIdr   = 4'd5;
  localparam logic [3:0] NalSei   = 4'd6;
  localparam logic [3:0] NalSps   = 4'd7;
  localparam logic [3:0] NalPps   = 4'd8;

  localparam logic [LENGTH_BITS-1:0] LenMax = '1;
  localparam logic [31:0] FrameNumLast = 32'hFFFF_FFFE;

  typedef struct packed {
    logic       active;     // lookahead full, a byte leaves it this beat
    logic       code_head;  // start code begins at the leaving byte
    logic       code_next;  // start code begins one byte later
    logic [3:0] hdr_type;   // type nibble of the header after code_head
    logic [7:0] lead_byte;  // byte leaving the lookahead
  } la_step_t;

  typedef struct packed {
    logic [7:0]             out_byte;
    logic                   frame_first;
    logic                   frame_last;
    logic                   key_frame;
    logic [31:0]            frame_number;
    logic [LENGTH_BITS-1:0] frame_length;
  } res_t;

  function automatic logic code_at(input logic [7:0] b0, input logic [7:0] b1,
                                   input logic [7:0] b2, input logic [7:0] b3);
    return (b0 == ScZero) && (b1 == ScZero) && (b2 == ScZero) && (b3 == ScOne);
  endfunction

  // Types that continue the current frame instead of opening a new one.
  function automatic logic joins_frame(input logic [3:0] t);
    return (t == NalIdr) || (t == NalSei) || (t == NalPps);
  endfunction

endpackage

`default_nettype wire

>>> rtl/h264fs_stream_if.sv
// Valid/ready channel interfaces for the stream bytes and the framed result.
// Depends on h264fs_pkg for the length width.
`timescale 1ns / 1ps
`default_nettype none

interface h264fs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface h264fs_out_if;
  import h264fs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [7:0]             out_byte;
  logic                   frame_first;
  logic                   frame_last;
  logic                   key_frame;
  logic [31:0]            frame_number;
  logic [LENGTH_BITS-1:0] frame_length;

  modport source (output valid, output out_byte, output frame_first, output frame_last,
                  output key_frame, output frame_number, output frame_length,
                  input ready);
  modport sink   (input valid, input out_byte, input frame_first, input frame_last,
                  input key_frame, input frame_number, input frame_length,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/h264fs_lookahead.sv
// Five-byte lookahead line with fill count and start code detection.
// Depends on h264fs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module h264fs_lookahead (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire logic [7:0]            byte_i,
  output      h264fs_pkg::la_step_t  step_o
);
  import h264fs_pkg::*;

  logic [7:0]         la_q [LaDepth];
  logic [7:0]         la_d [LaDepth];
  logic [LaFillW-1:0] fill_q, fill_d;
  logic               full;

  assign full = (fill_q == LaFillW'(LaDepth));

  always_comb begin
    la_d   = la_q;
    fill_d = fill_q;
    if (accept_i) begin
      if (!full) begin
        // Fill in order until the line is complete.
        for (int i = 0; i < LaDepth; i++) begin
          if (fill_q == LaFillW'(i)) begin
            la_d[i] = byte_i;
          end
        end
        fill_d = fill_q + LaFillW'(1);
      end else begin
        for (int i = 0; i < LaDepth - 1; i++) begin
          la_d[i] = la_q[i+1];
        end
        la_d[LaDepth-1] = byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Contents are only read once the fill count says they were written.
  always_ff @(posedge clk_i) begin
    la_q <= la_d;
  end

  always_comb begin
    step_o.active    = full;
    step_o.code_head = code_at(la_q[0], la_q[1], la_q[2], la_q[3]);
    step_o.code_next = code_at(la_q[1], la_q[2], la_q[3], la_q[4]);
    step_o.hdr_type  = la_q[4][3:0];
    step_o.lead_byte = la_q[0];
  end

endmodule

`default_nettype wire

>>> rtl/h264fs_framer.sv
// Frame state: sync, frame type, byte count and frame number; forms the result.
// Depends on h264fs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module h264fs_framer (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire logic [7:0]            byte_i,
  input  wire h264fs_pkg::la_step_t  step_i,
  output      logic                  res_valid_o,
  output      h264fs_pkg::res_t      res_o
);
  import h264fs_pkg::*;

  logic                   synced_q, synced_d;
  logic                   kept_q, kept_d;
  logic                   key_q, key_d;
  logic                   first_pending_q, first_pending_d;
  logic [LENGTH_BITS-1:0] count_q, count_d;
  logic [31:0]            fnum_q, fnum_d;

  logic                   in_frame;
  logic                   opening;
  logic                   kept;
  logic                   key;
  logic [LENGTH_BITS-1:0] base;
  logic [LENGTH_BITS-1:0] count_n;
  logic                   last;

  always_comb begin
    in_frame = synced_q || step_i.code_head;
    opening  = first_pending_q || (!synced_q && step_i.code_head);
    kept     = opening ? ((step_i.hdr_type == NalSlice) || (step_i.hdr_type == NalSps))
                       : kept_q;
    key      = opening ? (step_i.hdr_type == NalSps) : key_q;
    base     = opening ? '0 : count_q;
    count_n  = (base != LenMax) ? base + LENGTH_BITS'(1) : base;
    last     = step_i.code_next && !joins_frame(byte_i[3:0]);

    res_o.out_byte     = step_i.lead_byte;
    res_o.frame_first  = opening;
    res_o.frame_last   = last;
    res_o.key_frame    = key;
    res_o.frame_number = fnum_q;
    res_o.frame_length = count_n;

    synced_d        = synced_q;
    kept_d          = kept_q;
    key_d           = key_q;
    first_pending_d = first_pending_q;
    count_d         = count_q;
    fnum_d          = fnum_q;
    res_valid_o     = 1'b0;

    if (accept_i && step_i.active && in_frame) begin
      synced_d        = 1'b1;
      kept_d          = kept;
      key_d           = key;
      count_d         = count_n;
      first_pending_d = last;
      res_valid_o     = kept;
      if (last && kept) begin
        fnum_d = (fnum_q == FrameNumLast) ? '0 : fnum_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      synced_q        <= 1'b0;
      kept_q          <= 1'b0;
      key_q           <= 1'b0;
      first_pending_q <= 1'b0;
      count_q         <= '0;
      fnum_q          <= '0;
    end else begin
      synced_q        <= synced_d;
      kept_q          <= kept_d;
      key_q           <= key_d;
      first_pending_q <= first_pending_d;
      count_q         <= count_d;
      fnum_q          <= fnum_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/h264fs_out_stage.sv
// Output register with one skid entry; ready is taken from a register.
// Depends on h264fs_pkg and h264fs_out_if.
`timescale 1ns / 1ps
`default_nettype none

module h264fs_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire h264fs_pkg::res_t  res_i,
  output      logic              in_ready_o,
  h264fs_out_if.source           out_o
);
  import h264fs_pkg::*;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t main_q, main_d;
  res_t skid_q, skid_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_o.ready) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        main_d      = res_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = res_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign in_ready_o         = !skid_valid_q;
  assign out_o.valid        = out_valid_q;
  assign out_o.out_byte     = main_q.out_byte;
  assign out_o.frame_first  = main_q.frame_first;
  assign out_o.frame_last   = main_q.frame_last;
  assign out_o.key_frame    = main_q.key_frame;
  assign out_o.frame_number = main_q.frame_number;
  assign out_o.frame_length = main_q.frame_length;

endmodule

`default_nettype wire

>>> rtl/h264_annexb_frame_splitter_core.sv
// Top level of the H.264 Annex B frame splitter.
// Depends on h264fs_pkg, h264fs_stream_if, h264fs_lookahead, h264fs_framer, h264fs_out_stage.
//
//   channel | dir | beat contents                                        | accepted when
//   --------+-----+------------------------------------------------------+-----------------
//   in_i    | in  | in_byte                                              | valid && ready
//   out_o   | out | out_byte, frame_first/last, key_frame, number, length | valid && ready
//
// One stream byte is taken every clock while in_i.ready is high; a result beat reaches
// out_o from the output register. Output lags input by the five-byte lookahead line.
// Reset (rst_ni low, asynchronous) empties the lookahead and forgets sync and counters.
// in_i.ready falls only when both the output register and its skid entry hold beats,
// so a stalled sink costs at most one extra buffered beat before input is held off.
`timescale 1ns / 1ps
`default_nettype none

module h264_annexb_frame_splitter_core (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  h264fs_in_if.sink     in_i,
  h264fs_out_if.source  out_o
);
  import h264fs_pkg::*;

  logic     accept;
  logic     in_ready;
  la_step_t step;
  logic     res_valid;
  res_t     res;

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  // Hold the last five bytes; flag start codes at the head and one byte behind it.
  h264fs_lookahead u_lookahead (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_i.in_byte),
    .step_o   (step)
  );

  // Advance the frame state for each leaving byte and decide whether it is emitted.
  h264fs_framer u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (in_i.in_byte),
    .step_i      (step),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Register the result; park one beat in the skid entry while the sink stalls.
  h264fs_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .res_i      (res),
    .in_ready_o (in_ready),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

>>> rtl/h264fs_checker.sv
// Port-level checker for the frame splitter, bound to the top level.
// Depends on h264fs_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "h264_annexb_frame_splitter_core_defines.svh"

module h264fs_checker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_ready_i,
  input  wire logic                              out_valid_i,
  input  wire logic                              out_ready_i,
  input  wire logic [7:0]                        out_byte_i,
  input  wire logic                              frame_first_i,
  input  wire logic                              frame_last_i,
  input  wire logic                              key_frame_i,
  input  wire logic [31:0]                       frame_number_i,
  input  wire logic [h264fs_pkg::LENGTH_BITS-1:0] frame_length_i
);
  import h264fs_pkg::*;

  logic        expect_first_q;
  logic        key_q;
  logic [31:0] num_q;
  logic        beat;

  assign beat = out_valid_i && out_ready_i;

  // Track the frame the last delivered beat belonged to.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_first_q <= 1'b1;
      key_q          <= 1'b0;
      num_q          <= '0;
    end else if (beat) begin
      expect_first_q <= frame_last_i;
      key_q          <= key_frame_i;
      num_q          <= frame_number_i;
    end
  end

  `H264FS_ASSERT(a_stall_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(frame_length_i))
  `H264FS_ASSERT_IMP(a_first_follows_last, clk_i, rst_ni, out_valid_i, frame_first_i == expect_first_q)
  `H264FS_ASSERT_IMP(a_first_len_one, clk_i, rst_ni, out_valid_i && frame_first_i, frame_length_i == LENGTH_BITS'(1))
  `H264FS_ASSERT_IMP(a_frame_attrs_steady, clk_i, rst_ni, out_valid_i && !frame_first_i, (frame_number_i == num_q) && (key_frame_i == key_q) && (frame_length_i != '0))
  `H264FS_ASSERT_IMP(a_backpressure_only_when_full, clk_i, rst_ni, !in_ready_i, out_valid_i)

endmodule

bind h264_annexb_frame_splitter_core h264fs_checker u_h264fs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_byte_i     (out_o.out_byte),
  .frame_first_i  (out_o.frame_first),
  .frame_last_i   (out_o.frame_last),
  .key_frame_i    (out_o.key_frame),
  .frame_number_i (out_o.frame_number),
  .frame_length_i (out_o.frame_length)
);

`default_nettype wire
